// File: rtl/core/pds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pds_pkg
// Shared widths, constants and pipeline word type for the Phong shader.
// ----------------------------------------------------------------------------
package pds_pkg;

   localparam int FRAC     = 14;              // fraction bits of all terms
   localparam int ONE_W    = FRAC + 1;        // clamped term, 0..1.0
   localparam int COMP_W   = 16;              // vector component width
   localparam int COLOR_W  = 16;              // one colour channel
   localparam int NCHAN    = 3;
   localparam int SHIN_W   = 8;               // exponent bits, one cell each
   localparam int OUT_W    = 18;
   localparam int PROD_W   = 2 * COMP_W;
   localparam int DOT_W    = 2 * COMP_W + 2;
   localparam int TERM_W   = ONE_W + 2 * COLOR_W - 2 * FRAC;
   localparam int CSR_IDX_W = 2;

   localparam logic [ONE_W-1:0] ONE     = ONE_W'(1) << FRAC;
   localparam logic [OUT_W-1:0] OUT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_RED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_GREEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_BLUE  = 2'd2;

   typedef logic [NCHAN-1:0][COLOR_W-1:0] pds_color_type;

   // word handed from cell to cell
   typedef struct packed {
      logic                valid;
      logic [ONE_W-1:0]    r;      // running power
      logic [ONE_W-1:0]    x;      // specular base
      logic [SHIN_W-1:0]   expo;   // remaining exponent bits, MSB next
      logic [ONE_W-1:0]    diff;
      pds_color_type       cd;
      pds_color_type       cs;
   } pds_item_type;

endpackage
`default_nettype wire

// File: rtl/core/pds_dot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pds_dot
// Front end: diffuse and specular dot products, clamp to 0..1.0, builds the
// word that enters the power chain.
// ----------------------------------------------------------------------------
module pds_dot import pds_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic signed [COMP_W-1:0]    normal_x,
   input  wire logic signed [COMP_W-1:0]    normal_y,
   input  wire logic signed [COMP_W-1:0]    normal_z,
   input  wire logic signed [COMP_W-1:0]    light_dir_x,
   input  wire logic signed [COMP_W-1:0]    light_dir_y,
   input  wire logic signed [COMP_W-1:0]    light_dir_z,
   input  wire logic signed [COMP_W-1:0]    reflect_x,
   input  wire logic signed [COMP_W-1:0]    reflect_y,
   input  wire logic signed [COMP_W-1:0]    reflect_z,
   input  wire logic [NCHAN*COLOR_W-1:0]    diffuse_color,
   input  wire logic [NCHAN*COLOR_W-1:0]    specular_color,
   input  wire logic [SHIN_W-1:0]           shininess,
   output      pds_item_type                item_o
);

   localparam int T_W = DOT_W - 1 - FRAC;

   logic signed [PROD_W-1:0] pn_ff [NCHAN];
   logic signed [PROD_W-1:0] pn_in [NCHAN];
   logic signed [PROD_W-1:0] pr_ff [NCHAN];
   logic signed [PROD_W-1:0] pr_in [NCHAN];
   logic                     valid_ff;
   logic [NCHAN*COLOR_W-1:0] cd_ff;
   logic [NCHAN*COLOR_W-1:0] cs_ff;
   logic [SHIN_W-1:0]        shin_ff;
   pds_item_type             item_ff;
   pds_item_type             item_in;
   logic signed [DOT_W-1:0]  sum_n;
   logic signed [DOT_W-1:0]  sum_r;
   logic [ONE_W-1:0]         diff;

   function automatic logic [ONE_W-1:0] clamp_term(input logic signed [DOT_W-1:0] s);
      logic [T_W-1:0] t;
      t = s[DOT_W-2:FRAC];
      if (s <= 0)
         return '0;
      else if (t > T_W'(ONE))
         return ONE;
      else
         return t[ONE_W-1:0];
   endfunction

   always_comb begin
      pn_in[0] = normal_x * light_dir_x;
      pn_in[1] = normal_y * light_dir_y;
      pn_in[2] = normal_z * light_dir_z;
      pr_in[0] = reflect_x * light_dir_x;
      pr_in[1] = reflect_y * light_dir_y;
      pr_in[2] = reflect_z * light_dir_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      pn_ff   <= pn_in;
      pr_ff   <= pr_in;
      cd_ff   <= diffuse_color;
      cs_ff   <= specular_color;
      shin_ff <= shininess;
   end

   always_comb begin
      sum_n = DOT_W'(pn_ff[0]) + DOT_W'(pn_ff[1]) + DOT_W'(pn_ff[2]);
      sum_r = DOT_W'(pr_ff[0]) + DOT_W'(pr_ff[1]) + DOT_W'(pr_ff[2]);
      diff  = clamp_term(sum_n);
      item_in.valid = valid_ff;
      item_in.r     = ONE;
      // no specular highlight on the unlit side
      item_in.x     = (diff == '0) ? '0 : clamp_term(sum_r);
      item_in.expo  = shin_ff;
      item_in.diff  = diff;
      item_in.cd    = cd_ff;
      item_in.cs    = cs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff <= item_in;
      end
   end

   assign item_o = item_ff;

endmodule
`default_nettype wire

// File: rtl/core/pds_pow_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pds_pow_cell
// One exponent bit of the power: square, then multiply by the base when the
// current exponent MSB is set. Two register stages per cell.
// ----------------------------------------------------------------------------
module pds_pow_cell import pds_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire pds_item_type item_i,
   output      pds_item_type item_o
);

   logic [2*ONE_W-1:0] sq;
   logic [2*ONE_W-1:0] mul;
   pds_item_type       sq_ff;
   pds_item_type       sq_in;
   pds_item_type       mul_ff;
   pds_item_type       mul_in;

   always_comb begin
      sq      = item_i.r * item_i.r;
      sq_in   = item_i;
      sq_in.r = sq[FRAC +: ONE_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff.valid <= 1'b0;
      end else begin
         sq_ff <= sq_in;
      end
   end

   always_comb begin
      mul         = sq_ff.r * sq_ff.x;
      mul_in      = sq_ff;
      mul_in.expo = sq_ff.expo << 1;
      if (sq_ff.expo[SHIN_W-1]) begin
         mul_in.r = mul[FRAC +: ONE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff.valid <= 1'b0;
      end else begin
         mul_ff <= mul_in;
      end
   end

   assign item_o = mul_ff;

endmodule
`default_nettype wire

// File: rtl/core/pds_shade.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pds_shade
// Back end: term * material colour * light colour per channel, sum and
// saturate into the result register.
// ----------------------------------------------------------------------------
module pds_shade import pds_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pds_item_type       item_i,
   input  wire pds_color_type      light,
   output      logic               rsp_valid,
   output      logic [OUT_W-1:0]   rsp_red,
   output      logic [OUT_W-1:0]   rsp_green,
   output      logic [OUT_W-1:0]   rsp_blue
);

   localparam int MA_W = ONE_W + COLOR_W;
   localparam int MB_W = MA_W + COLOR_W;

   logic [MA_W-1:0]    pd_ff [NCHAN];
   logic [MA_W-1:0]    pd_in [NCHAN];
   logic [MA_W-1:0]    ps_ff [NCHAN];
   logic [MA_W-1:0]    ps_in [NCHAN];
   logic               va_ff;
   logic [MB_W-1:0]    td    [NCHAN];
   logic [MB_W-1:0]    ts    [NCHAN];
   logic [TERM_W-1:0]  td_ff [NCHAN];
   logic [TERM_W-1:0]  ts_ff [NCHAN];
   logic               vb_ff;
   logic [TERM_W:0]    sum   [NCHAN];
   logic [OUT_W-1:0]   out_in [NCHAN];
   logic [OUT_W-1:0]   out_ff [NCHAN];
   logic               vc_ff;

   always_comb begin
      for (int c = 0; c < NCHAN; c++) begin
         pd_in[c] = item_i.diff * item_i.cd[c];
         ps_in[c] = item_i.r * item_i.cs[c];
      end
   end

   always_comb begin
      for (int c = 0; c < NCHAN; c++) begin
         td[c] = pd_ff[c] * light[c];
         ts[c] = ps_ff[c] * light[c];
      end
   end

   always_comb begin
      for (int c = 0; c < NCHAN; c++) begin
         sum[c]    = (TERM_W+1)'(td_ff[c]) + (TERM_W+1)'(ts_ff[c]);
         out_in[c] = (sum[c] > (TERM_W+1)'(OUT_MAX)) ? OUT_MAX : sum[c][OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= item_i.valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
      for (int c = 0; c < NCHAN; c++) begin
         pd_ff[c]  <= pd_in[c];
         ps_ff[c]  <= ps_in[c];
         td_ff[c]  <= td[c][2*FRAC +: TERM_W];
         ts_ff[c]  <= ts[c][2*FRAC +: TERM_W];
         out_ff[c] <= out_in[c];
      end
   end

   assign rsp_valid = vc_ff;
   assign rsp_red   = out_ff[0];
   assign rsp_green = out_ff[1];
   assign rsp_blue  = out_ff[2];

endmodule
`default_nettype wire

// File: rtl/core/phong_diffuse_specular_shader.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phong_diffuse_specular_shader
// Phong diffuse plus specular shading, one evaluation per request word.
// ----------------------------------------------------------------------------
// Request channel: drive start with the req_ fields; the word is taken at a
// rising edge where start is high and busy is low. busy is low except while
// reset is held, so a new word can be taken every cycle.
// Response channel: rsp_valid strobes for one cycle with rsp_red, rsp_green
// and rsp_blue. The receiver cannot stall; results leave in request order.
// Pipeline: 2 front-end stages (dot products, clamp), 16 stages of the power
// chain (one cell per shininess bit, square then multiply in each), and 3
// back-end stages (two multiplies, sum and saturate).
// Throughput: one word per cycle, fixed by the fully pipelined cell chain.
// Light colour registers sit on the csr_ port (index 0 red, 1 green,
// 2 blue; index 3 is ignored); csr_ready is always high. Write them only
// while no request is in flight.
// Reset clears all in-flight words and sets each light channel to 1.0.
// ----------------------------------------------------------------------------
module phong_diffuse_specular_shader import pds_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output      logic                        busy,
   input  wire logic signed [COMP_W-1:0]    req_normal_x,
   input  wire logic signed [COMP_W-1:0]    req_normal_y,
   input  wire logic signed [COMP_W-1:0]    req_normal_z,
   input  wire logic signed [COMP_W-1:0]    req_light_dir_x,
   input  wire logic signed [COMP_W-1:0]    req_light_dir_y,
   input  wire logic signed [COMP_W-1:0]    req_light_dir_z,
   input  wire logic signed [COMP_W-1:0]    req_reflect_x,
   input  wire logic signed [COMP_W-1:0]    req_reflect_y,
   input  wire logic signed [COMP_W-1:0]    req_reflect_z,
   input  wire logic [NCHAN*COLOR_W-1:0]    req_diffuse_color,
   input  wire logic [NCHAN*COLOR_W-1:0]    req_specular_color,
   input  wire logic [SHIN_W-1:0]           req_shininess,
   output      logic                        rsp_valid,
   output      logic [OUT_W-1:0]            rsp_red,
   output      logic [OUT_W-1:0]            rsp_green,
   output      logic [OUT_W-1:0]            rsp_blue,
   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [COLOR_W-1:0]          csr_wdata
);

   logic          accept;
   pds_color_type light_ff;
   pds_color_type light_in;
   pds_item_type  chain [SHIN_W+1];

   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_comb begin
      light_in = light_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LIGHT_RED:   light_in[0] = csr_wdata;
            CSR_LIGHT_GREEN: light_in[1] = csr_wdata;
            CSR_LIGHT_BLUE:  light_in[2] = csr_wdata;
            default:         light_in    = light_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NCHAN; c++) begin
            light_ff[c] <= COLOR_W'(ONE);
         end
      end else begin
         light_ff <= light_in;
      end
   end

   pds_dot u_dot (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .normal_x       (req_normal_x),
      .normal_y       (req_normal_y),
      .normal_z       (req_normal_z),
      .light_dir_x    (req_light_dir_x),
      .light_dir_y    (req_light_dir_y),
      .light_dir_z    (req_light_dir_z),
      .reflect_x      (req_reflect_x),
      .reflect_y      (req_reflect_y),
      .reflect_z      (req_reflect_z),
      .diffuse_color  (req_diffuse_color),
      .specular_color (req_specular_color),
      .shininess      (req_shininess),
      .item_o         (chain[0])
   );

   // one cell per exponent bit, MSB first
   for (genvar k = 0; k < SHIN_W; k++) begin : g_cell
      pds_pow_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .item_i (chain[k]),
         .item_o (chain[k+1])
      );
   end

   pds_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .item_i    (chain[SHIN_W]),
      .light     (light_ff),
      .rsp_valid (rsp_valid),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

endmodule
`default_nettype wire
